// ===== rtl/multi_pin_trigger_debouncer_macros.svh =====
// ----------------------------------------------------------------------------
// Multi-pin trigger debouncer assertion macros
// Shared concurrent assertion forms for the debouncer checkers.
// ----------------------------------------------------------------------------
`ifndef MULTI_PIN_TRIGGER_DEBOUNCER_MACROS_SVH
`define MULTI_PIN_TRIGGER_DEBOUNCER_MACROS_SVH

// Check a property on every clock edge outside of reset
`define MPTD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("debouncer check failed");

// Check a property on every clock edge, reset included
`define MPTD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("debouncer check failed");

`endif

// ===== rtl/mptd_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-pin trigger debouncer package
// Widths, register indexes and lane control type shared by the debouncer.
// ----------------------------------------------------------------------------
package mptd_pkg;

  // Pins carried by one transaction and by the configuration masks
  localparam int unsigned FIELD_PIN_COUNT = 8;
  // Hold count fields packed into each 64-bit hold register
  localparam int unsigned HOLD_FIELD_W    = 16;
  localparam int unsigned PINS_PER_REG    = 4;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned CFG_INDEX_W     = 2;

  // Default parameter values
  localparam int unsigned DEF_PIN_COUNT   = 8;
  localparam int unsigned DEF_COUNT_WIDTH = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PIN_ENABLE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_LOW     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_HIGH    = 2'd3;

  // Per-pin control handed to a lane on each tick
  typedef struct packed {
    logic enable;
    logic level;
    logic trigger;
  } lane_ctrl_t;

endpackage

// ===== rtl/mptd_lane.sv =====
// ----------------------------------------------------------------------------
// Debouncer lane
// Hold counter, elapsed latch and reported bit for one pin.
// ----------------------------------------------------------------------------
module mptd_lane #(
  parameter int unsigned COUNT_WIDTH = mptd_pkg::DEF_COUNT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  mptd_pkg::lane_ctrl_t   ctrl,
  input  logic [COUNT_WIDTH-1:0] hold_count,
  output logic                   state_next
);

  logic [COUNT_WIDTH-1:0] counter;
  logic [COUNT_WIDTH-1:0] counter_next;
  logic                   elapsed;
  logic                   elapsed_next;
  logic                   reported;
  logic                   reported_next;

  // Work out this pin's next state for one poll tick
  always_comb begin
    counter_next  = counter;
    elapsed_next  = elapsed;
    reported_next = reported;
    if (!ctrl.enable) begin
      counter_next = '0;
      elapsed_next = 1'b0;
    end else if (ctrl.level != ctrl.trigger) begin
      reported_next = ctrl.level;
      counter_next  = '0;
      elapsed_next  = 1'b0;
    end else if (!elapsed) begin
      if (counter >= hold_count) begin
        reported_next = ctrl.level;
        elapsed_next  = 1'b1;
      end else begin
        counter_next = counter + 1'b1;
      end
    end
  end

  assign state_next = reported_next;

  // Advance on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      counter  <= '0;
      elapsed  <= 1'b0;
      reported <= 1'b0;
    end else if (step) begin
      counter  <= counter_next;
      elapsed  <= elapsed_next;
      reported <= reported_next;
    end
  end

endmodule

// ===== rtl/mptd_merge.sv =====
// ----------------------------------------------------------------------------
// Debouncer merge stage
// Gathers lane states into one result and holds it for the output handshake.
// ----------------------------------------------------------------------------
module mptd_merge #(
  parameter int unsigned LANE_COUNT = mptd_pkg::DEF_PIN_COUNT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  logic [LANE_COUNT-1:0]                lane_states,
  output logic                                 slot_free,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mptd_pkg::FIELD_PIN_COUNT-1:0] debounced_states
);

  localparam int unsigned OUT_W = mptd_pkg::FIELD_PIN_COUNT;

  logic [OUT_W-1:0] merged;

  // Place lane bits at their pin positions, absent pins read zero
  assign merged = OUT_W'(lane_states);

  // Slot opens when empty or drained in this cycle
  assign slot_free = !out_valid || out_ready;

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      debounced_states <= merged;
    end
  end

endmodule

// ===== rtl/multi_pin_trigger_debouncer.sv =====
// ----------------------------------------------------------------------------
// Multi-pin trigger debouncer
// Counter based debouncer with one lane per pin and a registered result.
//
//   Channel  Signals                          Width  Direction
//   in       in_valid / in_ready, pin_levels  8      consumer
//   out      out_valid / out_ready,
//            debounced_states                 8      producer
//   cfg      cfg_write, cfg_index, cfg_data   2/64   write only
//
// One poll tick per cycle while in_ready is high; its result is valid in the cycle after acceptance.
// All lanes update together in the accepting cycle; the merge stage
// registers the gathered bits.
// A new tick is taken while the held result is being drained.
// in_ready drops only while a result waits and out_ready is low.
// rst clears counters, latches, reported bits, config and out_valid, but not debounced_states.
// ----------------------------------------------------------------------------
module multi_pin_trigger_debouncer #(
  parameter int unsigned PIN_COUNT   = mptd_pkg::DEF_PIN_COUNT,
  parameter int unsigned COUNT_WIDTH = mptd_pkg::DEF_COUNT_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [mptd_pkg::FIELD_PIN_COUNT-1:0] pin_levels,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mptd_pkg::FIELD_PIN_COUNT-1:0] debounced_states,
  input  logic                                 cfg_write,
  input  logic [mptd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mptd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Pins past the mask width have no enable and never change
  localparam int unsigned LANE_COUNT =
    (PIN_COUNT < mptd_pkg::FIELD_PIN_COUNT) ? PIN_COUNT : mptd_pkg::FIELD_PIN_COUNT;
  localparam int unsigned FW = mptd_pkg::HOLD_FIELD_W;

  logic [mptd_pkg::FIELD_PIN_COUNT-1:0] pin_enable_mask;
  logic [mptd_pkg::FIELD_PIN_COUNT-1:0] trigger_level_mask;
  logic [mptd_pkg::CFG_DATA_W-1:0]      hold_counts_low_pins;
  logic [mptd_pkg::CFG_DATA_W-1:0]      hold_counts_high_pins;

  logic                  slot_free;
  logic                  step;
  logic [LANE_COUNT-1:0] lane_states;

  // Decode configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pin_enable_mask       <= '0;
      trigger_level_mask    <= '0;
      hold_counts_low_pins  <= '0;
      hold_counts_high_pins <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mptd_pkg::REG_PIN_ENABLE: begin
          pin_enable_mask <= cfg_data[mptd_pkg::FIELD_PIN_COUNT-1:0];
        end
        mptd_pkg::REG_TRIGGER: begin
          trigger_level_mask <= cfg_data[mptd_pkg::FIELD_PIN_COUNT-1:0];
        end
        mptd_pkg::REG_HOLD_LOW: begin
          hold_counts_low_pins <= cfg_data;
        end
        mptd_pkg::REG_HOLD_HIGH: begin
          hold_counts_high_pins <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Accept a tick whenever the result slot can take its result
  assign in_ready = slot_free;
  assign step     = in_valid && in_ready;

  // One lane per pin
  for (genvar n = 0; n < LANE_COUNT; n++) begin : g_lane
    localparam int unsigned SLOT = n % mptd_pkg::PINS_PER_REG;

    logic [FW-1:0]          hold_field;
    logic [COUNT_WIDTH-1:0] hold_count;
    mptd_pkg::lane_ctrl_t   ctrl;

    if (n < mptd_pkg::PINS_PER_REG) begin : g_low
      assign hold_field = hold_counts_low_pins[SLOT*FW +: FW];
    end else begin : g_high
      assign hold_field = hold_counts_high_pins[SLOT*FW +: FW];
    end

    // Fit the 16-bit field to the counter width
    if (COUNT_WIDTH <= FW) begin : g_trunc
      assign hold_count = hold_field[COUNT_WIDTH-1:0];
    end else begin : g_ext
      assign hold_count = COUNT_WIDTH'(hold_field);
    end

    assign ctrl.enable  = pin_enable_mask[n];
    assign ctrl.level   = pin_levels[n];
    assign ctrl.trigger = trigger_level_mask[n];

    mptd_lane #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk        (clk),
      .rst        (rst),
      .step       (step),
      .ctrl       (ctrl),
      .hold_count (hold_count),
      .state_next (lane_states[n])
    );
  end

  // Gather lane states into the output register
  mptd_merge #(
    .LANE_COUNT (LANE_COUNT)
  ) u_merge (
    .clk              (clk),
    .rst              (rst),
    .load             (step),
    .lane_states      (lane_states),
    .slot_free        (slot_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .debounced_states (debounced_states)
  );

endmodule

// ===== rtl/mptd_checker.sv =====
// ----------------------------------------------------------------------------
// Debouncer port checker
// Watches the debouncer's handshakes and flags ordering or loss slips.
// ----------------------------------------------------------------------------
`include "multi_pin_trigger_debouncer_macros.svh"

module mptd_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [mptd_pkg::FIELD_PIN_COUNT-1:0] debounced_states
);

  // A waiting result holds still
  `MPTD_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(debounced_states))

  // Every accepted tick shows a result in the next cycle
  `MPTD_ASSERT(a_result_follows, clk, rst, in_valid && in_ready |=> out_valid)

  // No tick is taken over a result that is still pending
  `MPTD_ASSERT(a_no_overwrite, clk, rst, out_valid && !out_ready |-> !in_ready)

  // Reset leaves no result behind
  `MPTD_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

endmodule

bind multi_pin_trigger_debouncer mptd_checker u_mptd_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .debounced_states (debounced_states)
);
